[hw/rtl/slcd_pkg.sv]
// shared types and constants of the sync / length / checksum deframer
package slcd_pkg;

	// frame buffer size in bytes (8 to 256)
	localparam int BUFFER_BYTES = 256;

	localparam int POS_W = 9;
	localparam int COUNT_W = 32;
	localparam int SUM_W = 16;

	localparam logic [POS_W-1:0] BUF_LIMIT = POS_W'(BUFFER_BYTES);
	localparam logic [POS_W-1:0] LEN_POS = POS_W'(2);

	localparam logic [7:0] SYNC_FIRST = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam logic [7:0] MIN_CHECKED_LENGTH = 8'd4;

	// one result item
	typedef struct packed {
		logic byte_taken;
		logic [7:0] byte_position;
		logic frame_done;
		logic frame_good;
		logic [COUNT_W-1:0] good_frames;
		logic [COUNT_W-1:0] bad_frames;
	} result_t;

endpackage

[hw/rtl/slcd_byte_if.sv]
// channel interfaces: received bytes in, per-byte results out
interface slcd_byte_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
	modport monitor (input valid, input rx_byte, input ready);
endinterface

interface slcd_result_if;
	logic valid;
	logic ready;
	logic byte_taken;
	logic [7:0] byte_position;
	logic frame_done;
	logic frame_good;
	logic [31:0] good_frames;
	logic [31:0] bad_frames;

	modport source (output valid, output byte_taken, output byte_position, output frame_done,
		output frame_good, output good_frames, output bad_frames, input ready);
	modport sink (input valid, input byte_taken, input byte_position, input frame_done,
		input frame_good, input good_frames, input bad_frames, output ready);
	modport monitor (input valid, input byte_taken, input byte_position, input frame_done,
		input frame_good, input good_frames, input bad_frames, input ready);
endinterface

[hw/rtl/slcd_track.sv]
// frame tracker: sync hunt, length capture, running sum, check and counters
module slcd_track (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] rx_byte,
	output slcd_pkg::result_t result
);
	import slcd_pkg::*;

	logic in_frame_q;
	logic first_sync_q;
	logic [POS_W-1:0] wr_pos_q;
	logic [7:0] frame_len_q;
	logic [SUM_W-1:0] sum_q;
	logic [7:0] prev_byte_q;
	logic [COUNT_W-1:0] good_cnt_q;
	logic [COUNT_W-1:0] bad_cnt_q;

	logic in_frame_d;
	logic first_sync_d;
	logic [POS_W-1:0] wr_pos_d;
	logic [7:0] frame_len_d;
	logic [SUM_W-1:0] sum_d;
	logic [7:0] prev_byte_d;
	logic [COUNT_W-1:0] good_cnt_d;
	logic [COUNT_W-1:0] bad_cnt_d;

	logic [7:0] len_eff;
	logic [POS_W-1:0] pos_inc;
	logic [SUM_W-1:0] check_sum;
	logic taken;
	logic done;
	logic good;

	// length in force for this byte: the length byte itself at position two
	assign len_eff = (wr_pos_q == LEN_POS) ? rx_byte : frame_len_q;
	assign pos_inc = wr_pos_q + POS_W'(1);
	// the last two bytes leave the sum again, so the check uses the sum before them
	assign check_sum = ~(sum_q - SUM_W'(prev_byte_q));

	// next state and result for the byte in hand
	always_comb begin
		in_frame_d = in_frame_q;
		first_sync_d = first_sync_q;
		wr_pos_d = wr_pos_q;
		frame_len_d = frame_len_q;
		sum_d = sum_q;
		prev_byte_d = prev_byte_q;
		good_cnt_d = good_cnt_q;
		bad_cnt_d = bad_cnt_q;
		taken = 1'b0;
		done = 1'b0;
		good = 1'b0;
		if (in_frame_q) begin
			frame_len_d = len_eff;
			if (wr_pos_q < BUF_LIMIT) begin
				taken = 1'b1;
				sum_d = sum_q + SUM_W'(rx_byte);
				prev_byte_d = rx_byte;
				wr_pos_d = pos_inc;
				if (pos_inc >= {1'b0, len_eff} && len_eff > MIN_CHECKED_LENGTH) begin
					done = 1'b1;
					sum_d = check_sum;
					good = (check_sum == {rx_byte, prev_byte_q});
					if (good) begin
						good_cnt_d = good_cnt_q + COUNT_W'(1);
					end else begin
						bad_cnt_d = bad_cnt_q + COUNT_W'(1);
					end
					wr_pos_d = '0;
					in_frame_d = 1'b0;
					first_sync_d = 1'b0;
				end
			end else begin
				// overflow: drop the frame silently and hunt again
				wr_pos_d = '0;
				in_frame_d = 1'b0;
				first_sync_d = 1'b0;
			end
		end else begin
			if (rx_byte == SYNC_FIRST) begin
				first_sync_d = 1'b1;
			end else begin
				if (rx_byte == SYNC_SECOND && first_sync_q) begin
					in_frame_d = 1'b1;
					wr_pos_d = LEN_POS;
					sum_d = '0;
				end
				first_sync_d = 1'b0;
			end
		end
	end

	// result fields
	always_comb begin
		result.byte_taken = taken;
		result.byte_position = taken ? wr_pos_q[7:0] : 8'd0;
		result.frame_done = done;
		result.frame_good = good;
		result.good_frames = good_cnt_d;
		result.bad_frames = bad_cnt_d;
	end

	// state registers, updated per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			first_sync_q <= 1'b0;
			wr_pos_q <= '0;
			frame_len_q <= '0;
			sum_q <= '0;
			prev_byte_q <= '0;
			good_cnt_q <= '0;
			bad_cnt_q <= '0;
		end else if (step) begin
			in_frame_q <= in_frame_d;
			first_sync_q <= first_sync_d;
			wr_pos_q <= wr_pos_d;
			frame_len_q <= frame_len_d;
			sum_q <= sum_d;
			prev_byte_q <= prev_byte_d;
			good_cnt_q <= good_cnt_d;
			bad_cnt_q <= bad_cnt_d;
		end
	end

endmodule

[hw/rtl/slcd_result_reg.sv]
// result register: holds one result until the sink takes it
module slcd_result_reg (
	input logic clk,
	input logic arst_n,
	input logic load,
	input slcd_pkg::result_t result,
	output logic can_load,
	slcd_result_if.source res
);
	import slcd_pkg::*;

	logic valid_q;
	result_t data_q;

	// a new result may enter when the slot is empty or drains this cycle
	assign can_load = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= result;
		end
	end

	assign res.valid = valid_q;
	assign res.byte_taken = data_q.byte_taken;
	assign res.byte_position = data_q.byte_position;
	assign res.frame_done = data_q.frame_done;
	assign res.frame_good = data_q.frame_good;
	assign res.good_frames = data_q.good_frames;
	assign res.bad_frames = data_q.bad_frames;

endmodule

[hw/rtl/sync_length_checksum_deframer_unit.sv]
// top level of the sync / length / checksum deframer
// Takes one received byte per transaction and returns one registered result per byte in the next cycle,
// at a rate of one byte per clock: the whole per-byte update (sync hunt, length capture,
// 16-bit sum, checksum compare, 32-bit frame counters) is one level of logic in front of a
// single result register, and a new byte is taken whenever that register is empty or is
// being read. Frames start after 0x55 0xAA; the byte at position 2 is the frame length;
// stored bytes are reported with their position so the frame can be kept outside. A frame
// longer than the buffer is dropped without any flag. Counters wrap at 32 bits.
module sync_length_checksum_deframer_unit (
	input logic clk,
	input logic arst_n,
	slcd_byte_if.sink byte_ch,
	slcd_result_if.source result_ch
);
	import slcd_pkg::*;

	result_t result;
	logic can_load;
	logic step;

	assign byte_ch.ready = can_load;
	assign step = byte_ch.valid && can_load;

	// per-byte state update
	slcd_track u_track (
		.clk (clk),
		.arst_n (arst_n),
		.step (step),
		.rx_byte (byte_ch.rx_byte),
		.result (result)
	);

	// output register
	slcd_result_reg u_result_reg (
		.clk (clk),
		.arst_n (arst_n),
		.load (byte_ch.valid),
		.result (result),
		.can_load (can_load),
		.res (result_ch)
	);

endmodule

[hw/rtl/slcd_checker.sv]
// port-level assertions for the deframer, bound to the top level
module slcd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic res_valid,
	input logic res_ready,
	input logic res_taken,
	input logic [7:0] res_pos,
	input logic res_done,
	input logic res_good,
	input logic [31:0] res_good_frames,
	input logic [31:0] res_bad_frames
);

	// a stalled result transaction keeps its frame counters and byte position
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid
		&& $stable(res_good_frames) && $stable(res_bad_frames)
		&& $stable(res_pos))
	else $error("stalled result changed");

	// an empty result slot always takes a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> in_ready)
	else $error("input stalled with empty result slot");

	// a completed frame ends on a stored byte, a good flag only on a completed frame
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_good || res_done)
		|-> res_done && res_taken)
	else $error("frame flags inconsistent");

	// a byte not stored reports position zero, and frames start at position two
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_taken ? (res_pos >= 8'd2) : (res_pos == 8'd0)))
	else $error("byte position inconsistent");

endmodule

bind sync_length_checksum_deframer_unit slcd_checker u_checker (
	.clk (clk),
	.arst_n (arst_n),
	.in_ready (byte_ch.ready),
	.res_valid (result_ch.valid),
	.res_ready (result_ch.ready),
	.res_taken (result_ch.byte_taken),
	.res_pos (result_ch.byte_position),
	.res_done (result_ch.frame_done),
	.res_good (result_ch.frame_good),
	.res_good_frames (result_ch.good_frames),
	.res_bad_frames (result_ch.bad_frames)
);

[tb/tb.sv]
// self-checking testbench of the sync / length / checksum deframer
`timescale 1ns / 1ps

module tb;
	import slcd_pkg::*;

	logic clk;
	logic arst_n;

	slcd_byte_if byte_ch();
	slcd_result_if result_ch();

	sync_length_checksum_deframer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.result_ch(result_ch)
	);

	// bytes waiting to be sent and per-byte results predicted for them
	logic [7:0] rx_stream_q[$];
	result_t predicted_results[$];

	// deframer state as predicted
	logic hunt_armed;
	logic framing;
	logic [POS_W-1:0] wr_pos;
	logic [7:0] frame_len;
	logic [SUM_W-1:0] frame_sum;
	logic [7:0] last_byte;
	logic [COUNT_W-1:0] good_total;
	logic [COUNT_W-1:0] bad_total;
	int oversize_drops;

	int mismatches;
	int bytes_sent;
	logic byte_fire;

	// sender burst state and receiver stall state
	int burst_left;
	int gap_left;
	int stall_left;
	int rx_cycle;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("** sync_length_checksum_deframer_unit: FAILED **");
		$finish;
	end

	// per-byte update of the deframer, returns the result for this byte
	function automatic result_t deframe_byte(logic [7:0] b);
		result_t r;
		logic [15:0] received;
		r = '0;
		if (framing) begin
			if (wr_pos == LEN_POS)
				frame_len = b;
			if (wr_pos < BUF_LIMIT) begin
				r.byte_taken = 1'b1;
				r.byte_position = wr_pos[7:0];
				received = {b, last_byte};
				frame_sum = frame_sum + SUM_W'(b);
				last_byte = b;
				wr_pos = wr_pos + 1'b1;
				// frame complete: take the checksum bytes back out and compare
				if (wr_pos >= POS_W'(frame_len) && frame_len > MIN_CHECKED_LENGTH) begin
					frame_sum = frame_sum - SUM_W'(received[7:0]) - SUM_W'(b);
					frame_sum = ~frame_sum;
					r.frame_done = 1'b1;
					if (frame_sum == received) begin
						r.frame_good = 1'b1;
						good_total = good_total + 1'b1;
					end else begin
						bad_total = bad_total + 1'b1;
					end
					wr_pos = '0;
					framing = 1'b0;
					hunt_armed = 1'b0;
				end
			end else begin
				// buffer full: frame dropped without a flag
				oversize_drops++;
				wr_pos = '0;
				framing = 1'b0;
				hunt_armed = 1'b0;
			end
		end else begin
			if (b == SYNC_FIRST) begin
				hunt_armed = 1'b1;
			end else begin
				if (b == SYNC_SECOND && hunt_armed) begin
					framing = 1'b1;
					wr_pos = LEN_POS;
					frame_sum = '0;
				end
				hunt_armed = 1'b0;
			end
		end
		r.good_frames = good_total;
		r.bad_frames = bad_total;
		return r;
	endfunction

	// well-formed frame of the given total length, optionally with one bit flipped
	task automatic queue_frame(int len, bit corrupt);
		logic [7:0] f[];
		logic [15:0] sum;
		int idx;
		f = new[len];
		f[0] = SYNC_FIRST;
		f[1] = SYNC_SECOND;
		f[2] = 8'(len);
		sum = 16'(len);
		for (int k = 3; k < len - 2; k++) begin
			f[k] = 8'($urandom_range(0, 255));
			sum = sum + 16'(f[k]);
		end
		sum = ~sum;
		f[len - 2] = sum[7:0];
		f[len - 1] = sum[15:8];
		if (corrupt) begin
			idx = $urandom_range(3, len - 1);
			f[idx] = f[idx] ^ (8'h01 << $urandom_range(0, 7));
		end
		foreach (f[k])
			rx_stream_q.push_back(f[k]);
	endtask

	// frame with a short length: fills the buffer, the next byte is dropped
	task automatic queue_oversize_frame(int len);
		rx_stream_q.push_back(SYNC_FIRST);
		rx_stream_q.push_back(SYNC_SECOND);
		rx_stream_q.push_back(8'(len));
		for (int k = 3; k < BUFFER_BYTES; k++)
			rx_stream_q.push_back(8'($urandom_range(0, 255)));
		// dropped byte is a sync start; the following sync end must not lock
		rx_stream_q.push_back(SYNC_FIRST);
		rx_stream_q.push_back(SYNC_SECOND);
	endtask

	// stimulus, reset and end of run
	initial begin
		int frame_no;
		int ovf_a;
		int long_at;
		logic [7:0] nb;

		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.rx_byte = '0;
		result_ch.ready = 1'b0;
		framing = 1'b0;
		hunt_armed = 1'b0;
		wr_pos = '0;
		frame_len = '0;
		frame_sum = '0;
		last_byte = '0;
		good_total = '0;
		bad_total = '0;
		oversize_drops = 0;
		mismatches = 0;
		bytes_sent = 0;
		byte_fire = 1'b0;
		burst_left = 0;
		gap_left = 0;
		stall_left = 0;
		rx_cycle = 0;

		// directed: extreme bytes, lone sync end, broken sync
		rx_stream_q.push_back(8'h00);
		rx_stream_q.push_back(8'hFF);
		rx_stream_q.push_back(SYNC_SECOND);
		rx_stream_q.push_back(SYNC_FIRST);
		rx_stream_q.push_back(8'h12);
		rx_stream_q.push_back(SYNC_SECOND);
		// repeated sync start, shortest checked frame, good
		rx_stream_q.push_back(SYNC_FIRST);
		queue_frame(5, 1'b0);
		// bad checksum
		queue_frame(6, 1'b1);
		// sync bytes inside the payload
		rx_stream_q.push_back(SYNC_FIRST);
		rx_stream_q.push_back(SYNC_SECOND);
		rx_stream_q.push_back(8'h07);
		rx_stream_q.push_back(SYNC_FIRST);
		rx_stream_q.push_back(SYNC_SECOND);
		rx_stream_q.push_back(8'hF9);
		rx_stream_q.push_back(8'hFE);

		// random: mostly well-formed frames, some noise, one buffer-filling frame
		// and one frame of the longest length
		frame_no = 0;
		ovf_a = $urandom_range(1, 4);
		long_at = ovf_a + $urandom_range(1, 4);
		while (rx_stream_q.size() < 600 || frame_no <= long_at) begin
			if (frame_no == ovf_a) begin
				queue_oversize_frame($urandom_range(0, 4));
			end else if (frame_no == long_at) begin
				queue_frame(255, $urandom_range(0, 1) == 1);
			end else begin
				case ($urandom_range(0, 9))
					0: begin
						// broken sequences and line noise
						case ($urandom_range(0, 2))
							0: begin
								nb = 8'($urandom_range(0, 255));
								if (nb == SYNC_SECOND)
									nb = 8'h00;
								rx_stream_q.push_back(SYNC_FIRST);
								rx_stream_q.push_back(nb);
							end
							1: rx_stream_q.push_back(SYNC_SECOND);
							default: begin
								repeat ($urandom_range(1, 4))
									rx_stream_q.push_back(8'($urandom_range(0, 255)));
							end
						endcase
					end
					1: begin
						repeat ($urandom_range(1, 3))
							rx_stream_q.push_back(SYNC_FIRST);
						queue_frame($urandom_range(5, 24), $urandom_range(0, 3) == 0);
					end
					default: begin
						if ($urandom_range(0, 7) == 0)
							queue_frame($urandom_range(25, 64), $urandom_range(0, 3) == 0);
						else
							queue_frame($urandom_range(5, 24), $urandom_range(0, 3) == 0);
					end
				endcase
			end
			frame_no++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all bytes accepted, then all results back
		while (rx_stream_q.size() > 0 || byte_ch.valid)
			@(posedge clk);
		while (predicted_results.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (predicted_results.size() != 0)
			mismatches++;
		$display("covered %0d bytes: %0d good and %0d bad frames checked,", bytes_sent,
			good_total, bad_total);
		$display("%0d oversize frames dropped, random burst gaps and receiver stalls",
			oversize_drops);
		if (mismatches == 0) begin
			$display("** sync_length_checksum_deframer_unit: PASSED **");
		end else begin
			$display("** sync_length_checksum_deframer_unit: FAILED **");
		end
		$finish;
	end

	// monitor: check accepted results, predict accepted bytes
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got.byte_taken = result_ch.byte_taken;
				got.byte_position = result_ch.byte_position;
				got.frame_done = result_ch.frame_done;
				got.frame_good = result_ch.frame_good;
				got.good_frames = result_ch.good_frames;
				got.bad_frames = result_ch.bad_frames;
				if (predicted_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none expected", $realtime);
				end else begin
					want = predicted_results.pop_front();
					if (got.byte_taken !== want.byte_taken
							|| got.byte_position !== want.byte_position
							|| got.frame_done !== want.frame_done
							|| got.frame_good !== want.frame_good
							|| got.good_frames !== want.good_frames
							|| got.bad_frames !== want.bad_frames) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: expected taken %b pos %0d done %b good %b cnt %0d/%0d",
								$realtime, want.byte_taken, want.byte_position, want.frame_done,
								want.frame_good, want.good_frames, want.bad_frames);
							$display("%0t: actual   taken %b pos %0d done %b good %b cnt %0d/%0d",
								$realtime, got.byte_taken, got.byte_position, got.frame_done,
								got.frame_good, got.good_frames, got.bad_frames);
						end
					end
				end
			end
			if (byte_ch.valid && byte_ch.ready) begin
				predicted_results.push_back(deframe_byte(byte_ch.rx_byte));
				bytes_sent++;
				byte_fire <= 1'b1;
			end else begin
				byte_fire <= 1'b0;
			end
		end
	end

	// driver: bursts of random length with random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (byte_fire)
				void'(rx_stream_q.pop_front());
			if (byte_ch.valid && !byte_fire) begin
				// hold the current transaction
			end else begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
				if (gap_left > 0) begin
					gap_left--;
					byte_ch.valid <= 1'b0;
				end else if (rx_stream_q.size() > 0) begin
					byte_ch.valid <= 1'b1;
					byte_ch.rx_byte <= rx_stream_q[0];
					burst_left--;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, with stall-free stretches every third window
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (((rx_cycle >> 8) % 3) != 0 && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 8);
			end
		end
	end

endmodule
